// ===== rtl/touch_sample_filter_and_press_detect_core_assert.svh =====
// assertion macros for the touch filter core
`ifndef TOUCH_SAMPLE_FILTER_AND_PRESS_DETECT_CORE_ASSERT_SVH
`define TOUCH_SAMPLE_FILTER_AND_PRESS_DETECT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TSF_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication failed");
`define TSF_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define TSF_ASSERT_IMPLY(label, clk, rst, a, b)
`define TSF_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== rtl/tsf_pkg.sv =====
// ----------------------------------------------------------------------------
// tsf_pkg
// shared types and constants of the touch sample filter
// ----------------------------------------------------------------------------
package tsf_pkg;
  localparam int SMP_MAX_W = 16;
  localparam int POS_W = 4;
  localparam int GRP_W = 2;

  localparam logic [2:0] REG_X_GAIN = 3'd0;
  localparam logic [2:0] REG_X_OFFSET = 3'd1;
  localparam logic [2:0] REG_Y_GAIN = 3'd2;
  localparam logic [2:0] REG_Y_OFFSET = 3'd3;
  localparam logic [2:0] REG_AGREE_TOL = 3'd4;

  localparam logic EV_PRESS = 1'b0;
  localparam logic EV_RELEASE = 1'b1;

  localparam logic [17:0] X_GAIN_RST = 18'sd8366;
  localparam logic [10:0] X_OFFSET_RST = -11'sd20;
  localparam logic [17:0] Y_GAIN_RST = -18'sd5938;
  localparam logic [10:0] Y_OFFSET_RST = 11'sd349;
  localparam logic [11:0] AGREE_TOL_RST = 12'd50;

  typedef struct packed {
    logic                 rel;
    logic [SMP_MAX_W-1:0] smp;
    logic [POS_W-1:0]     pos;
    logic [GRP_W-1:0]     grp;
  } cmd_t;

  typedef struct packed {
    logic pressed;
    logic capturing;
  } front_stat_t;
endpackage

// ===== rtl/tsf_front.sv =====
// ----------------------------------------------------------------------------
// tsf_front
// accepts ticks and samples, tracks pen state, queues work for the back end
// ----------------------------------------------------------------------------
module tsf_front #(
  parameter int SAMPLES_PER_GROUP = 5,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  input  logic                pen_down,
  input  logic [11:0]         sample,
  input  logic                q_full,
  output logic                q_push,
  output tsf_pkg::cmd_t       q_data,
  output tsf_pkg::front_stat_t stat
);
  logic pressed, pressed_next;
  logic capturing, capturing_next;
  logic [tsf_pkg::POS_W-1:0] pos, pos_next;
  logic [tsf_pkg::GRP_W-1:0] grp, grp_next;
  logic accept;
  logic [SAMPLE_BITS-1:0] smp;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;
  assign smp = SAMPLE_BITS'(sample);
  assign stat.pressed = pressed;
  assign stat.capturing = capturing;

  always_comb begin
    pressed_next = pressed;
    capturing_next = capturing;
    pos_next = pos;
    grp_next = grp;
    q_push = 1'b0;
    q_data.rel = 1'b0;
    q_data.smp = tsf_pkg::SMP_MAX_W'(smp);
    q_data.pos = pos;
    q_data.grp = grp;
    if (accept) begin
      if (!op) begin
        if (pen_down) begin
          if (!pressed) begin
            pressed_next = 1'b1;
            capturing_next = 1'b1;
            pos_next = '0;
            grp_next = '0;
          end
        end else if (pressed) begin
          pressed_next = 1'b0;
          capturing_next = 1'b0;
          pos_next = '0;
          grp_next = '0;
          q_push = 1'b1;
          q_data.rel = 1'b1;
        end
      end else if (capturing) begin
        q_push = 1'b1;
        if (pos == tsf_pkg::POS_W'(SAMPLES_PER_GROUP - 1)) begin
          pos_next = '0;
          grp_next = grp + 1'b1;
          if (grp == '1) begin
            capturing_next = 1'b0;
          end
        end else begin
          pos_next = pos + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed <= 1'b0;
      capturing <= 1'b0;
      pos <= '0;
      grp <= '0;
    end else begin
      pressed <= pressed_next;
      capturing <= capturing_next;
      pos <= pos_next;
      grp <= grp_next;
    end
  end
endmodule

// ===== rtl/tsf_fifo.sv =====
// ----------------------------------------------------------------------------
// tsf_fifo
// short command queue between front and back end
// ----------------------------------------------------------------------------
module tsf_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tsf_pkg::cmd_t wdata,
  input  logic          pop,
  output tsf_pkg::cmd_t rdata,
  output logic          empty,
  output logic          full,
  output logic [2:0]    count
);
  tsf_pkg::cmd_t mem [4];
  logic [1:0] wptr, rptr;
  logic do_push, do_pop;

  assign empty = (count == 3'd0);
  assign full = (count == 3'd4);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      count <= count + 3'(do_push) - 3'(do_pop);
    end
  end
endmodule

// ===== rtl/tsf_back.sv =====
// ----------------------------------------------------------------------------
// tsf_back
// sorted insert, trimmed mean, pass agreement, calibration and event output
// ----------------------------------------------------------------------------
module tsf_back #(
  parameter int SAMPLES_PER_GROUP = 5,
  parameter int TRIM_EACH_END = 1,
  parameter int SAMPLE_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  tsf_pkg::cmd_t      q_data,
  output logic               q_pop,
  input  logic [17:0]        x_gain,
  input  logic [10:0]        x_offset,
  input  logic [17:0]        y_gain,
  input  logic [10:0]        y_offset,
  input  logic [11:0]        agree_tol,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               event_kind,
  output logic [9:0]         x_coord,
  output logic [9:0]         y_coord
);
  localparam int N = SAMPLES_PER_GROUP;
  localparam int TRIM = (2 * TRIM_EACH_END >= N) ? (N - 1) / 2 : TRIM_EACH_END;
  localparam int KEEP = N - 2 * TRIM;
  localparam int SB = SAMPLE_BITS;
  localparam int SUM_W = SB + 4;
  localparam int SH = SB + 9;
  localparam longint unsigned RECIP = ((64'd1 << SH) + KEEP - 1) / KEEP;
  localparam int RECIP_W = SH + 1;
  localparam int PW = 18 + SB + 1;
  localparam int TW = PW + 1;

  logic adv;
  logic [SB-1:0] sorted [N];
  logic [SB-1:0] ins [N];
  logic [SB-1:0] smp;
  logic last;

  logic s1_v, s1_rel;
  logic [1:0] s1_grp;
  logic s2_v, s2_rel;
  logic [1:0] s2_grp;
  logic [SUM_W-1:0] s2_sum, sum_c;
  logic s3_v, s3_rel;
  logic [1:0] s3_grp;
  logic [SB-1:0] s3_avg;
  logic [SUM_W+RECIP_W-1:0] quot_full;
  logic [SB-1:0] fa0, fa1, sa;
  logic s4_v, s4_rel;
  logic [SB-1:0] s4_a, s4_b;
  logic s5_v, s5_rel;
  logic signed [PW-1:0] s5_px, s5_py;
  logic [SB-1:0] da, db;
  logic agree;
  logic signed [TW-1:0] tx, ty;
  logic [9:0] cx, cy, cur_x, cur_y;

  function automatic logic [9:0] clamp10(input logic signed [TW-1:0] t);
    logic [TW-17:0] hi;
    hi = t[TW-1:16];
    if (t[TW-1]) return 10'd0;
    else if (hi > (TW-16)'(1023)) return 10'd1023;
    else return hi[9:0];
  endfunction

  assign adv = !out_valid || out_ready;
  assign q_pop = adv && !q_empty;
  assign smp = q_data.smp[SB-1:0];
  assign last = (q_data.pos == tsf_pkg::POS_W'(N - 1));

  // insertion into the sorted prefix of length pos
  always_comb begin
    for (int i = 0; i < N; i++) begin
      logic gt_i, gt_prev;
      gt_i = (i < int'(q_data.pos)) && (sorted[i] > smp);
      gt_prev = (i > 0) && ((i - 1) < int'(q_data.pos)) && (sorted[(i > 0) ? i - 1 : 0] > smp);
      if (gt_prev) ins[i] = sorted[(i > 0) ? i - 1 : 0];
      else if (gt_i || i == int'(q_data.pos)) ins[i] = smp;
      else ins[i] = sorted[i];
    end
  end

  always_comb begin
    sum_c = '0;
    for (int i = TRIM; i < N - TRIM; i++) begin
      sum_c = sum_c + SUM_W'(sorted[i]);
    end
  end

  assign quot_full = (SUM_W + RECIP_W)'(s2_sum) * (SUM_W + RECIP_W)'(RECIP_W'(RECIP));

  assign da = (fa0 > sa) ? fa0 - sa : sa - fa0;
  assign db = (fa1 > s3_avg) ? fa1 - s3_avg : s3_avg - fa1;
  assign agree = (SB + 1)'(da) < (SB + 1)'(agree_tol) && (SB + 1)'(db) < (SB + 1)'(agree_tol);

  assign tx = TW'(s5_px) + (TW'($signed(x_offset)) <<< 16);
  assign ty = TW'(s5_py) + (TW'($signed(y_offset)) <<< 16);
  assign cx = clamp10(tx);
  assign cy = clamp10(ty);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (q_pop && !q_data.rel) begin
        for (int i = 0; i < N; i++) sorted[i] <= ins[i];
      end
      s2_sum <= sum_c;
      s3_avg <= quot_full[SH +: SB];
      if (s3_v && !s3_rel) begin
        unique case (s3_grp)
          2'd0: fa0 <= s3_avg;
          2'd1: fa1 <= s3_avg;
          2'd2: sa <= s3_avg;
          default: ;
        endcase
      end
      s4_a <= SB'(((SB + 1)'(fa0) + (SB + 1)'(sa)) >> 1);
      s4_b <= SB'(((SB + 1)'(fa1) + (SB + 1)'(s3_avg)) >> 1);
      s5_px <= PW'($signed(x_gain) * $signed({1'b0, s4_b}));
      s5_py <= PW'($signed(y_gain) * $signed({1'b0, s4_a}));
      if (s5_v && !s5_rel) begin
        x_coord <= cx;
        y_coord <= cy;
        event_kind <= tsf_pkg::EV_PRESS;
      end else if (s5_v) begin
        x_coord <= cur_x;
        y_coord <= cur_y;
        event_kind <= tsf_pkg::EV_RELEASE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0; s1_rel <= 1'b0; s1_grp <= '0;
      s2_v <= 1'b0; s2_rel <= 1'b0; s2_grp <= '0;
      s3_v <= 1'b0; s3_rel <= 1'b0; s3_grp <= '0;
      s4_v <= 1'b0; s4_rel <= 1'b0;
      s5_v <= 1'b0; s5_rel <= 1'b0;
      cur_x <= '0; cur_y <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        // only releases and group-closing samples go downstream
        s1_v <= q_pop && (q_data.rel || last);
        s1_rel <= q_data.rel;
        s1_grp <= q_data.grp;
        s2_v <= s1_v; s2_rel <= s1_rel; s2_grp <= s1_grp;
        s3_v <= s2_v; s3_rel <= s2_rel; s3_grp <= s2_grp;
        s4_v <= s3_v && (s3_rel || (s3_grp == 2'd3 && agree));
        s4_rel <= s3_rel;
        s5_v <= s4_v; s5_rel <= s4_rel;
        if (s5_v && !s5_rel) begin
          cur_x <= cx;
          cur_y <= cy;
        end
        out_valid <= s5_v;
      end
    end
  end
endmodule

// ===== rtl/touch_sample_filter_and_press_detect_core.sv =====
// path: a capture's last sample or a pen-up tick passes the queue, stages s1 to s5 and the output register
// throughput: one item per cycle while the queue is not full; the front end never waits on the back end
// beyond the 4-entry queue, and the back pipeline stalls only on a full output
// reset: synchronous, clears pen state, queue, pipeline valids, last coordinates
// and loads the calibration registers with their defaults
// ----------------------------------------------------------------------------
// touch_sample_filter_and_press_detect_core
// touch sample trimmed-mean filter with press and release detection
// ----------------------------------------------------------------------------
`include "touch_sample_filter_and_press_detect_core_assert.svh"
module touch_sample_filter_and_press_detect_core #(
  parameter int SAMPLES_PER_GROUP = 5,
  parameter int TRIM_EACH_END = 1,
  parameter int SAMPLE_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic        pen_down,
  input  logic [11:0] sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        event_kind,
  output logic [9:0]  x_coord,
  output logic [9:0]  y_coord
);
  logic [17:0] x_gain, y_gain;
  logic [10:0] x_offset, y_offset;
  logic [11:0] agree_tol;
  logic [2:0] reg_idx;
  logic wr;

  logic q_push, q_pop, q_empty, q_full;
  logic [2:0] q_count;
  tsf_pkg::cmd_t q_wdata, q_rdata;
  tsf_pkg::front_stat_t stat;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_gain <= tsf_pkg::X_GAIN_RST;
      x_offset <= tsf_pkg::X_OFFSET_RST;
      y_gain <= tsf_pkg::Y_GAIN_RST;
      y_offset <= tsf_pkg::Y_OFFSET_RST;
      agree_tol <= tsf_pkg::AGREE_TOL_RST;
    end else if (wr) begin
      case (reg_idx)
        tsf_pkg::REG_X_GAIN: x_gain <= pwdata[17:0];
        tsf_pkg::REG_X_OFFSET: x_offset <= pwdata[10:0];
        tsf_pkg::REG_Y_GAIN: y_gain <= pwdata[17:0];
        tsf_pkg::REG_Y_OFFSET: y_offset <= pwdata[10:0];
        tsf_pkg::REG_AGREE_TOL: agree_tol <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tsf_pkg::REG_X_GAIN: prdata = {{14{x_gain[17]}}, x_gain};
      tsf_pkg::REG_X_OFFSET: prdata = {{21{x_offset[10]}}, x_offset};
      tsf_pkg::REG_Y_GAIN: prdata = {{14{y_gain[17]}}, y_gain};
      tsf_pkg::REG_Y_OFFSET: prdata = {{21{y_offset[10]}}, y_offset};
      tsf_pkg::REG_AGREE_TOL: prdata = {20'd0, agree_tol};
      default: prdata = '0;
    endcase
  end

  tsf_front #(
    .SAMPLES_PER_GROUP(SAMPLES_PER_GROUP),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .pen_down(pen_down), .sample(sample),
    .q_full(q_full), .q_push(q_push), .q_data(q_wdata), .stat(stat)
  );

  tsf_fifo u_fifo (
    .clk(clk), .rst(rst),
    .push(q_push), .wdata(q_wdata),
    .pop(q_pop), .rdata(q_rdata),
    .empty(q_empty), .full(q_full), .count(q_count)
  );

  tsf_back #(
    .SAMPLES_PER_GROUP(SAMPLES_PER_GROUP),
    .TRIM_EACH_END(TRIM_EACH_END),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk(clk), .rst(rst),
    .q_empty(q_empty), .q_data(q_rdata), .q_pop(q_pop),
    .x_gain(x_gain), .x_offset(x_offset), .y_gain(y_gain), .y_offset(y_offset),
    .agree_tol(agree_tol),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_kind(event_kind), .x_coord(x_coord), .y_coord(y_coord)
  );

  // a pen-up beat while pressed must leave a release waiting in the queue
  `TSF_ASSERT_NEXT(a_release_queued, clk, rst, in_valid && in_ready && !op && !pen_down && stat.pressed, !q_empty)
  // backpressure to the input only when the queue is really full
  `TSF_ASSERT_IMPLY(a_ready_vs_queue, clk, rst, !in_ready, q_count == 3'd4)
  // a capture only runs while the pen is held
  `TSF_ASSERT_IMPLY(a_capture_pressed, clk, rst, stat.capturing, stat.pressed)
endmodule
